FILE: rtl/bcsd_pkg.sv
// ----------------------------------------------------------------------------
// bcsd_pkg - shared types and constants for the biphase clock-synced decoder
// Sample and result beat layouts, sync phase encoding, delay line sizes.
// ----------------------------------------------------------------------------
package bcsd_pkg;

  localparam int SAMPLE_WIDTH  = 16;
  localparam int DATA_LAG      = 10;
  localparam int CLOCK_HISTORY = 244;

  // clock ring holds the current sample plus CLOCK_HISTORY older ones
  localparam int CLK_DEPTH = CLOCK_HISTORY + 1;
  localparam int CLK_AW    = $clog2(CLK_DEPTH);
  localparam int CNT_W     = $clog2(CLOCK_HISTORY + 1);
  localparam int DIFF_W    = ((CLK_AW > CNT_W) ? CLK_AW : CNT_W) + 1;

  localparam int LVL_W = 2;
  localparam logic signed [LVL_W-1:0] LEVEL_NONE = 2'sb00;
  localparam logic signed [LVL_W-1:0] LEVEL_FALL = 2'sb01;
  localparam logic signed [LVL_W-1:0] LEVEL_RISE = 2'sb11;

  typedef enum logic [1:0] {
    PH_UNSYNCED = 2'd0,
    PH_TIMING   = 2'd1,
    PH_SEEN     = 2'd2,
    PH_LOCKED   = 2'd3
  } phase_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] data_sample;
    logic signed [SAMPLE_WIDTH-1:0] clock_sample;
  } in_beat_t;

  typedef struct packed {
    logic signed [LVL_W-1:0]        decoded_level;
    logic signed [SAMPLE_WIDTH-1:0] aligned_clock;
  } out_beat_t;

endpackage

FILE: rtl/biphase_clock_synced_decoder_core.sv
// ----------------------------------------------------------------------------
// biphase_clock_synced_decoder_core - biphase decoder aligned to symbol clock
// Measures the offset between recovered clock edges and data crossings, then
// decides one level per falling edge of the offset-delayed clock.
// ----------------------------------------------------------------------------
//
//  port group | dir | handshake           | beat
//  -----------+-----+---------------------+-------------------------------
//  in_        | in  | in_valid/in_ready   | bcsd_pkg::in_beat_t  (samples)
//  out_       | out | out_valid/out_ready | bcsd_pkg::out_beat_t (level)
//
//  One beat in and one beat out per cycle while out_ready is high. The step is
//  computed in the cycle a beat is accepted; the result lands in a two-entry
//  output buffer. The clock history lives in a 1W2R RAM of sample pairs;
//  both candidate offsets are read from the post-step state into registers.
//  in_ready depends only on the skid entry, so a stalled out_ready costs at
//  most one extra beat of buffering before in_ready drops.
//  RAM entries not yet written read as zero via a fill pointer, so reset
//  needs no clearing pass.
// ----------------------------------------------------------------------------
module biphase_clock_synced_decoder_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bcsd_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bcsd_pkg::out_beat_t  out_data
);

  localparam int SW = bcsd_pkg::SAMPLE_WIDTH;
  localparam int AW = bcsd_pkg::CLK_AW;
  localparam int CW = bcsd_pkg::CNT_W;
  localparam int DW = bcsd_pkg::DIFF_W;

  // -------------------------------------------------------------- helpers
  function automatic logic signed [1:0] sgn(input logic signed [SW-1:0] v);
    logic signed [1:0] s;
    if (v > 0)      s = 2'sb01;
    else if (v < 0) s = 2'sb11;
    else            s = 2'sb00;
    return s;
  endfunction

  function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] wp,
                                              input logic [CW-1:0] off);
    logic [DW-1:0] diff;
    diff = DW'(wp) - DW'(off);
    if (diff[DW-1]) diff = diff + DW'(bcsd_pkg::CLK_DEPTH);
    return diff[AW-1:0];
  endfunction

  // -------------------------------------------------------------- state
  logic signed [SW-1:0] dline_r [bcsd_pkg::DATA_LAG];
  logic signed [SW-1:0] last_c_r;
  bcsd_pkg::phase_t     phase_r, phase_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        off_r, off_nxt;
  logic signed [1:0]    held_r, held_nxt;
  logic [AW-1:0]        wp_r, wp_nxt;
  logic                 wrapped_r, wrapped_nxt;

  // clock history RAM: entry k = {sample k, sample k-1}
  logic [2*SW-1:0]      clk_mem [bcsd_pkg::CLK_DEPTH];
  logic [2*SW-1:0]      rd0_q_r, rd1_q_r, wdat_r;
  logic                 hit0_r, hit1_r, vld0_r, vld1_r;
  logic [AW-1:0]        raddr0, raddr1;
  logic                 vld0_nxt, vld1_nxt;
  logic [2*SW-1:0]      wdata;

  bcsd_pkg::out_beat_t  out_r, out_nxt, skid_r, skid_nxt, res;
  logic                 out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;

  logic                 acc;
  logic signed [SW-1:0] d, c, past, a_s, b_s;
  logic [2*SW-1:0]      pair0, pair1;
  logic signed [1:0]    sd, sp;
  logic                 locking;

  assign in_ready  = !skid_valid_r;
  assign acc       = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign d     = in_data.data_sample;
  assign c     = in_data.clock_sample;
  assign past  = dline_r[bcsd_pkg::DATA_LAG-1];
  assign sd    = sgn(d);
  assign sp    = sgn(past);
  assign wdata = {c, last_c_r};

  // read data for the current committed state, with write-through bypass
  assign pair0 = hit0_r ? wdat_r : (vld0_r ? rd0_q_r : '0);
  assign pair1 = hit1_r ? wdat_r : (vld1_r ? rd1_q_r : '0);

  // -------------------------------------------------------------- step
  always_comb begin
    logic [CW-1:0] use_off;
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    off_nxt     = off_r;
    held_nxt    = held_r;
    wp_nxt      = wp_r;
    wrapped_nxt = wrapped_r;
    locking     = 1'b0;
    a_s         = '0;
    b_s         = '0;
    use_off     = off_r;

    if (acc) begin
      wp_nxt      = (wp_r == AW'(bcsd_pkg::CLK_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      wrapped_nxt = wrapped_r || (wp_r == '0);

      if (phase_r == bcsd_pkg::PH_TIMING) cnt_nxt = cnt_r + 1'b1;
      if (phase_r == bcsd_pkg::PH_TIMING && sd > sp) phase_nxt = bcsd_pkg::PH_SEEN;
      // timing cannot reach locked in one step, so locking uses cnt_r
      if (phase_r == bcsd_pkg::PH_SEEN && sd < sp) begin
        locking   = 1'b1;
        off_nxt   = cnt_r;
        phase_nxt = bcsd_pkg::PH_LOCKED;
      end
      use_off = off_nxt;

      if (use_off == '0) begin
        a_s = c;
        b_s = last_c_r;
      end else if (locking) begin
        a_s = pair1[2*SW-1:SW];
        b_s = pair1[SW-1:0];
      end else begin
        a_s = pair0[2*SW-1:SW];
        b_s = pair0[SW-1:0];
      end

      if (a_s < b_s) begin
        if (phase_nxt == bcsd_pkg::PH_UNSYNCED) begin
          cnt_nxt   = '0;
          phase_nxt = bcsd_pkg::PH_TIMING;
        end
        if (phase_nxt == bcsd_pkg::PH_LOCKED)
          held_nxt = (d < past) ? bcsd_pkg::LEVEL_FALL : bcsd_pkg::LEVEL_RISE;
      end

      if (cnt_nxt > CW'(bcsd_pkg::CLOCK_HISTORY - 1)) phase_nxt = bcsd_pkg::PH_UNSYNCED;
    end

    res.decoded_level = held_nxt;
    res.aligned_clock = a_s;
  end

  // reads for the next beat: held offset and, for a possible lock, the counter
  always_comb begin
    raddr0   = ring_back(wp_nxt, off_nxt);
    raddr1   = ring_back(wp_nxt, cnt_nxt);
    vld0_nxt = wrapped_nxt ||
               (raddr0 != '0 && (raddr0 < wp_nxt || wp_nxt == '0));
    vld1_nxt = wrapped_nxt ||
               (raddr1 != '0 && (raddr1 < wp_nxt || wp_nxt == '0));
  end

  // -------------------------------------------------------------- output buffer
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = res;
        out_valid_nxt = acc;
      end
    end else if (acc) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  // -------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= bcsd_pkg::PH_UNSYNCED;
      cnt_r        <= '0;
      off_r        <= '0;
      held_r       <= bcsd_pkg::LEVEL_NONE;
      wp_r         <= AW'(1);
      wrapped_r    <= 1'b0;
      last_c_r     <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
      vld0_r       <= 1'b0;
      vld1_r       <= 1'b0;
      hit0_r       <= 1'b0;
      hit1_r       <= 1'b0;
      for (int i = 0; i < bcsd_pkg::DATA_LAG; i++) dline_r[i] <= '0;
    end else begin
      phase_r      <= phase_nxt;
      cnt_r        <= cnt_nxt;
      off_r        <= off_nxt;
      held_r       <= held_nxt;
      wp_r         <= wp_nxt;
      wrapped_r    <= wrapped_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      vld0_r       <= vld0_nxt;
      vld1_r       <= vld1_nxt;
      hit0_r       <= acc && (raddr0 == wp_r);
      hit1_r       <= acc && (raddr1 == wp_r);
      if (acc) begin
        last_c_r   <= c;
        dline_r[0] <= d;
        for (int i = 1; i < bcsd_pkg::DATA_LAG; i++) dline_r[i] <= dline_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
    wdat_r <= wdata;
  end

  // clock history RAM
  always_ff @(posedge clk) begin
    if (acc) clk_mem[wp_r] <= wdata;
    rd0_q_r <= clk_mem[raddr0];
    rd1_q_r <= clk_mem[raddr1];
  end

  // -------------------------------------------------------------- assertions
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_locked_offset: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == bcsd_pkg::PH_LOCKED |-> off_r <= CW'(bcsd_pkg::CLOCK_HISTORY - 1))
    else $error("locked with offset beyond clock history");

  a_counter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(bcsd_pkg::CLOCK_HISTORY))
    else $error("offset counter ran past limit");

  a_level_code: assert property (@(posedge clk) disable iff (!rst_n)
    held_r != 2'sb10)
    else $error("illegal held level code");

  a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= AW'(bcsd_pkg::CLK_DEPTH - 1))
    else $error("clock ring pointer out of range");

endmodule
